[sv/pfd_pkg.sv]
// Package for the pose frame deframer: frame phase type, framing bytes,
// payload geometry and the record passed from the frame tracker to the top.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned WORD_COUNT  = 6;
   localparam int unsigned PAYLOAD_LEN = 24;
   localparam int unsigned INDEX_W     = 5;

   localparam logic [BYTE_W-1:0]  HDR_CR       = 8'h0d;
   localparam logic [BYTE_W-1:0]  HDR_LF       = 8'h0a;
   localparam logic [INDEX_W-1:0] PAYLOAD_LAST = INDEX_W'(PAYLOAD_LEN - 1);

   typedef enum logic [2:0] {
      PH_HUNT     = 3'd0,
      PH_HDR_LF   = 3'd1,
      PH_PAYLOAD  = 3'd2,
      PH_TRAIL_LF = 3'd3,
      PH_TRAIL_CR = 3'd4
   } phase_type;

   typedef struct packed {
      logic                              emit;
      logic [WORD_COUNT-1:0][WORD_W-1:0] words;
   } frame_type;

endpackage

`default_nettype wire

[sv/pfd_if.sv]
// Valid/ready channel interfaces for the pose frame deframer: received bytes
// in, decoded pose words out. Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pfd_req_if;
   logic                       valid;
   logic                       ready;
   logic [pfd_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [pfd_pkg::WORD_W-1:0] z_angle_bits;
   logic [pfd_pkg::WORD_W-1:0] x_angle_bits;
   logic [pfd_pkg::WORD_W-1:0] y_angle_bits;
   logic [pfd_pkg::WORD_W-1:0] position_x_bits;
   logic [pfd_pkg::WORD_W-1:0] position_y_bits;
   logic [pfd_pkg::WORD_W-1:0] yaw_rate_bits;

   modport source (output valid, output z_angle_bits, output x_angle_bits,
                   output y_angle_bits, output position_x_bits,
                   output position_y_bits, output yaw_rate_bits, input ready);
   modport sink   (input valid, input z_angle_bits, input x_angle_bits,
                   input y_angle_bits, input position_x_bits,
                   input position_y_bits, input yaw_rate_bits, output ready);
endinterface

`default_nettype wire

[sv/pfd_frame_fsm.sv]
// Frame tracker: header/payload/trailer phase machine and the 24-byte payload
// shift line. Flags a completed frame with its six little-endian words.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfd_frame_fsm (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       byte_take,
   input  wire logic [pfd_pkg::BYTE_W-1:0] rx_byte,
   output pfd_pkg::frame_type              frame
);

   pfd_pkg::phase_type                 phase_ff, phase_in;
   logic [pfd_pkg::INDEX_W-1:0]        index_ff, index_in;
   logic [pfd_pkg::BYTE_W-1:0]         store_ff [pfd_pkg::PAYLOAD_LEN];
   logic                               store_shift;

   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      if (byte_take) begin
         case (phase_ff)
            pfd_pkg::PH_HUNT: begin
               phase_in = (rx_byte == pfd_pkg::HDR_CR) ? pfd_pkg::PH_HDR_LF
                                                       : pfd_pkg::PH_HUNT;
            end
            pfd_pkg::PH_HDR_LF: begin
               if (rx_byte == pfd_pkg::HDR_LF) begin
                  index_in = '0;
                  phase_in = pfd_pkg::PH_PAYLOAD;
               end else if (rx_byte != pfd_pkg::HDR_CR) begin
                  phase_in = pfd_pkg::PH_HUNT;
               end
            end
            pfd_pkg::PH_PAYLOAD: begin
               if (index_ff >= pfd_pkg::PAYLOAD_LAST) begin
                  index_in = '0;
                  phase_in = pfd_pkg::PH_TRAIL_LF;
               end else begin
                  index_in = index_ff + 1'b1;
               end
            end
            pfd_pkg::PH_TRAIL_LF: begin
               phase_in = (rx_byte == pfd_pkg::HDR_LF) ? pfd_pkg::PH_TRAIL_CR
                                                       : pfd_pkg::PH_HUNT;
            end
            default: begin
               phase_in = pfd_pkg::PH_HUNT;
            end
         endcase
      end
   end

   always_comb begin
      store_shift = byte_take && (phase_ff == pfd_pkg::PH_PAYLOAD);
      frame.emit  = byte_take && (phase_ff == pfd_pkg::PH_TRAIL_CR)
                    && (rx_byte == pfd_pkg::HDR_CR);
      for (int k = 0; k < pfd_pkg::WORD_COUNT; k++) begin
         frame.words[k] = {store_ff[4*k+3], store_ff[4*k+2],
                           store_ff[4*k+1], store_ff[4*k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pfd_pkg::PH_HUNT;
         index_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
      end
   end

   // oldest payload byte ends in entry 0
   always_ff @(posedge clock) begin
      if (store_shift) begin
         for (int i = 0; i < pfd_pkg::PAYLOAD_LEN - 1; i++) begin
            store_ff[i] <= store_ff[i+1];
         end
         store_ff[pfd_pkg::PAYLOAD_LEN-1] <= rx_byte;
      end
   end

   a_trail_after_payload: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == pfd_pkg::PH_TRAIL_LF && $past(phase_ff) != pfd_pkg::PH_TRAIL_LF) |->
         ($past(phase_ff) == pfd_pkg::PH_PAYLOAD && $past(index_ff) == pfd_pkg::PAYLOAD_LAST))
      else $error("trailer phase entered without a full payload");

   a_index_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      (index_ff != '0) |-> (phase_ff == pfd_pkg::PH_PAYLOAD))
      else $error("payload index nonzero outside payload phase");

   a_emit_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      frame.emit |=> (phase_ff == pfd_pkg::PH_HUNT && index_ff == '0))
      else $error("frame completion did not return to header search");

endmodule

`default_nettype wire

[sv/pose_frame_deframer.sv]
// Pose frame deframer top level: frame tracker plus the registered result
// stage on the rsp channel. Depends on pfd_pkg, pfd_if and pfd_frame_fsm.
// Output: a result appears on rsp in the cycle after the closing 0x0d is taken.
// Throughput: one byte per cycle; req stalls only while a result is held
// in the output register and rsp is not ready.
// Reset: synchronous; returns to header search and drops any held result.
`timescale 1ns / 1ps
`default_nettype none

module pose_frame_deframer (
   input  wire logic  clock,
   input  wire logic  reset,
   pfd_req_if.sink    req_bus,
   pfd_rsp_if.source  rsp_bus
);

   pfd_pkg::frame_type                                  frame;
   logic                                                req_take;
   logic                                                rsp_take;
   logic                                                rsp_valid_ff, rsp_valid_in;
   logic [pfd_pkg::WORD_COUNT-1:0][pfd_pkg::WORD_W-1:0] rsp_words_ff;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign rsp_take      = rsp_valid_ff && rsp_bus.ready;

   pfd_frame_fsm u_frame (
      .clock     (clock),
      .reset     (reset),
      .byte_take (req_take),
      .rx_byte   (req_bus.rx_byte),
      .frame     (frame)
   );

   always_comb begin
      if (frame.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame.emit) begin
         rsp_words_ff <= frame.words;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.z_angle_bits    = rsp_words_ff[0];
   assign rsp_bus.x_angle_bits    = rsp_words_ff[1];
   assign rsp_bus.y_angle_bits    = rsp_words_ff[2];
   assign rsp_bus.position_x_bits = rsp_words_ff[3];
   assign rsp_bus.position_y_bits = rsp_words_ff[4];
   assign rsp_bus.yaw_rate_bits   = rsp_words_ff[5];

   a_result_from_closing_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |->
         ($past(req_take) && $past(req_bus.rx_byte) == pfd_pkg::HDR_CR))
      else $error("result raised without a closing 0x0d transaction");

   a_emit_loads_result: assert property (@(posedge clock) disable iff (reset)
      frame.emit |=> (rsp_valid_ff && rsp_words_ff == $past(frame.words)))
      else $error("completed frame not loaded into result register");

   a_drain_clears_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && !frame.emit) |=> !rsp_valid_ff)
      else $error("result repeated after its transaction");

endmodule

`default_nettype wire
